FILE: hw/rtl/sxd_pkg.sv
// shared types and constants of the stx/etx card deframer
// no dependencies; imported by the core, the byte unit and the testbench
package sxd_pkg;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_IDLE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [7:0]  START_BYTE   = 8'h02;
  localparam logic [7:0]  END_BYTE     = 8'h03;
  localparam int          MIN_FRAME    = 5;
  localparam int          FRAME_OVH    = 4;
  localparam logic [15:0] SINCE_MAX    = 16'hFFFF;
  localparam logic [15:0] WINDOW_RESET = 16'd1000;

  // result of the shared byte unit
  typedef struct packed {
    logic [7:0] y;
    logic       eq;
  } bu_res_t;

endpackage

FILE: hw/rtl/sxd_byte_unit.sv
// shared byte unit: xor of two bytes and equality of the same pair
// depends on sxd_pkg
module sxd_byte_unit
  import sxd_pkg::*;
(
  input  logic [7:0] a,
  input  logic [7:0] b,
  output bu_res_t    res
);

  always_comb begin
    res.y  = a ^ b;
    // equality reuses the xor
    res.eq = (res.y == 8'h00);
  end

endmodule

FILE: hw/rtl/stx_etx_xor_card_deframer_dedup_core.sv
// stx/etx card frame deframer with xor check and repeat suppression
// depends on sxd_pkg and sxd_byte_unit
//
// input channel: in_valid/in_stall carries op and rx_byte, one event per beat.
// output channel: out_valid/out_stall carries one result per beat; an event
// gives one status beat, or one beat per uid byte when a card is reported.
// cfg_wen/cfg_wdata write the dedup window in ms; the user must write it only
// while the block is idle, which the block itself does not enforce.
// a non-closing event is accepted, then its status beat is loaded.
// an etx byte that may close a frame walks the frame store through the shared
// byte unit, one byte a cycle over its one read port: the xor walk of the frame,
// then the uid compare when the lengths match; a decide step follows, then a
// read and an output load for each reported uid byte.
// in_stall is high from the accept until the last beat of the event is loaded
// into the output register; a waiting result does not block the next accept.
// out_stall holds the output register and the sequencer waits on it.
// rst is synchronous, active high: counters, dedup state and framing clear,
// the window returns to 1000 ms; stores need no clearing.
module stx_etx_xor_card_deframer_dedup_core
  import sxd_pkg::*;
#(
  parameter int UID_MAX   = 10,
  parameter int FRAME_CAP = 18
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_card,
  output logic [7:0]  card_kind,
  output logic [4:0]  uid_length,
  output logic [3:0]  uid_index,
  output logic [7:0]  uid_byte,
  output logic        last_of_card,
  output logic [31:0] good_frames,
  output logic [31:0] bad_frames,
  output logic [31:0] cards_reported,
  output logic [31:0] cards_suppressed
);

  localparam int SA = $clog2(FRAME_CAP);
  localparam int CW = $clog2(FRAME_CAP + 1);
  localparam int PA = (UID_MAX > 1) ? $clog2(UID_MAX) : 1;
  localparam int UW = $clog2(UID_MAX + 1);
  localparam int MAX_CLOSE = UID_MAX + FRAME_OVH;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_STATUS   = 7'b0000010,
    S_XOR      = 7'b0000100,
    S_CMP      = 7'b0001000,
    S_DEC      = 7'b0010000,
    S_EMIT_RD  = 7'b0100000,
    S_EMIT_OUT = 7'b1000000
  } state_t;

  state_t         state;
  logic [15:0]    window;
  logic           collecting;
  logic [CW-1:0]  frame_count;
  logic [UW-1:0]  prior_len;
  logic           prior_valid;
  logic [15:0]    since_ms;
  logic [31:0]    cnt_good, cnt_bad, cnt_rep, cnt_sup;
  logic [CW-1:0]  ra;
  logic           dv;
  logic [CW-1:0]  da;
  logic [7:0]     chk;
  logic [7:0]     type_byte;
  logic [UW-1:0]  ulen;
  logic           same;

  logic [7:0]     store [FRAME_CAP];
  logic [7:0]     prior [UID_MAX];
  logic [7:0]     st_rd, pr_rd;

  logic           acc, full, issue_x, issue_c, slot_free, ld_status, ld_card;
  logic           st_we, st_re, pr_re, pr_we, closing;
  logic [SA-1:0]  st_addr;
  logic [PA-1:0]  pr_addr;
  logic [CW-1:0]  n_new, xor_last, uid_last;
  logic [7:0]     bu_a, bu_b;
  bu_res_t        bu;

  sxd_byte_unit u_bu (
    .a   (bu_a),
    .b   (bu_b),
    .res (bu)
  );

  always_comb begin
    in_stall  = (state != S_IDLE);
    acc       = in_valid && (state == S_IDLE);
    full      = (frame_count >= CW'(FRAME_CAP));
    n_new     = frame_count + CW'(1);
    xor_last  = frame_count - CW'(2);
    uid_last  = CW'(ulen) - CW'(1);
    issue_x   = (state == S_XOR) && (ra <= xor_last);
    issue_c   = (state == S_CMP) && (ra < CW'(ulen));
    slot_free = !out_valid || !out_stall;
    ld_status = (state == S_STATUS) && slot_free;
    ld_card   = (state == S_EMIT_OUT) && slot_free;
    st_we     = acc && (op == OP_BYTE) && collecting && !full;
    // an etx byte that makes a frame of closable size starts the check
    closing   = st_we && (rx_byte == END_BYTE) && (n_new >= CW'(MIN_FRAME)) &&
                (n_new <= CW'(MAX_CLOSE));
    st_re     = issue_x || issue_c || (state == S_EMIT_RD);
    // uid bytes sit two places into the frame
    st_addr   = (state == S_XOR) ? ra[SA-1:0] : SA'(ra + CW'(2));
    pr_re     = issue_c;
    pr_we     = ld_card;
    pr_addr   = ra[PA-1:0];
    bu_a      = (state == S_CMP) ? pr_rd : chk;
    bu_b      = st_rd;
  end

  always_ff @(posedge clk) begin
    if (st_we) store[frame_count[SA-1:0]] <= rx_byte;
    if (st_re) st_rd <= store[st_addr];
  end

  always_ff @(posedge clk) begin
    if (pr_we) prior[pr_addr] <= st_rd;
    if (pr_re) pr_rd <= prior[pr_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      window      <= WINDOW_RESET;
      collecting  <= 1'b0;
      frame_count <= '0;
      prior_len   <= '0;
      prior_valid <= 1'b0;
      since_ms    <= '0;
      cnt_good    <= '0;
      cnt_bad     <= '0;
      cnt_rep     <= '0;
      cnt_sup     <= '0;
      ra          <= '0;
      dv          <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wen) window <= cfg_wdata;
      out_valid <= ld_status || ld_card || (out_valid && out_stall);
      dv <= issue_x || issue_c;
      da <= ra;
      if (issue_x || issue_c) ra <= ra + CW'(1);

      case (state)
        S_IDLE: begin
          if (acc) begin
            state <= closing ? S_XOR : S_STATUS;
            case (op)
              OP_BYTE: begin
                if (!collecting) begin
                  if (rx_byte == START_BYTE) begin
                    collecting  <= 1'b1;
                    frame_count <= '0;
                  end
                end else if (full) begin
                  // overflow drops the frame, a start byte restarts at once
                  cnt_bad     <= cnt_bad + 32'd1;
                  frame_count <= '0;
                  collecting  <= (rx_byte == START_BYTE);
                end else begin
                  frame_count <= n_new;
                  if (closing) begin
                    ulen <= UW'(n_new - CW'(FRAME_OVH));
                    chk  <= 8'h00;
                    ra   <= '0;
                  end
                end
              end
              OP_IDLE: begin
                if (collecting) begin
                  cnt_bad     <= cnt_bad + 32'd1;
                  collecting  <= 1'b0;
                  frame_count <= '0;
                end
              end
              OP_TICK: begin
                if (since_ms != SINCE_MAX) since_ms <= since_ms + 16'd1;
              end
              OP_CLEAR: begin
                prior_valid <= 1'b0;
                since_ms    <= '0;
              end
              default: ;
            endcase
          end
        end
        S_STATUS: begin
          if (slot_free) state <= S_IDLE;
        end
        S_XOR: begin
          if (dv) begin
            if (da == xor_last) begin
              // accumulated xor against the check byte
              if (!bu.eq) begin
                state <= S_STATUS;
              end else if (prior_valid && prior_len == ulen) begin
                same  <= 1'b1;
                ra    <= '0;
                state <= S_CMP;
              end else begin
                same  <= 1'b0;
                state <= S_DEC;
              end
            end else begin
              chk <= bu.y;
              if (da == CW'(1)) type_byte <= st_rd;
            end
          end
        end
        S_CMP: begin
          if (dv) begin
            if (!bu.eq) same <= 1'b0;
            if (da == uid_last) state <= S_DEC;
          end
        end
        S_DEC: begin
          cnt_good    <= cnt_good + 32'd1;
          since_ms    <= '0;
          collecting  <= 1'b0;
          frame_count <= '0;
          if (same && since_ms < window) begin
            cnt_sup <= cnt_sup + 32'd1;
            state   <= S_STATUS;
          end else begin
            cnt_rep     <= cnt_rep + 32'd1;
            prior_len   <= ulen;
            prior_valid <= 1'b1;
            ra          <= '0;
            state       <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (slot_free) begin
            if (ra == uid_last) begin
              state <= S_IDLE;
            end else begin
              ra    <= ra + CW'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload, loaded with the counters as they stand after the event
  always_ff @(posedge clk) begin
    if (ld_status || ld_card) begin
      good_frames      <= cnt_good;
      bad_frames       <= cnt_bad;
      cards_reported   <= cnt_rep;
      cards_suppressed <= cnt_sup;
    end
    if (ld_status) begin
      is_card      <= 1'b0;
      card_kind    <= 8'h00;
      uid_length   <= 5'd0;
      uid_index    <= 4'd0;
      uid_byte     <= 8'h00;
      last_of_card <= 1'b1;
    end else if (ld_card) begin
      is_card      <= 1'b1;
      card_kind    <= type_byte;
      uid_length   <= 5'(ulen);
      uid_index    <= 4'(ra);
      uid_byte     <= st_rd;
      last_of_card <= (ra == uid_last);
    end
  end

endmodule

FILE: hw/rtl/sxd_checker.sv
// port-level checks of the card deframer core, bound to the top level
// depends only on the core's ports
module sxd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        is_card,
  input logic [7:0]  card_kind,
  input logic [4:0]  uid_length,
  input logic [3:0]  uid_index,
  input logic [7:0]  uid_byte,
  input logic        last_of_card
);

  // every accepted beat leaves the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(uid_byte) && $stable(uid_index)
      && $stable(is_card) && $stable(last_of_card))
    else $error("stalled result changed");

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_card |-> last_of_card && uid_length == 5'd0 &&
      uid_index == 4'd0 && uid_byte == 8'h00 && card_kind == 8'h00)
    else $error("malformed status result");

  // uid index stays inside the card and the last beat sits at its end
  a_card_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_card |-> ({1'b0, uid_index} < uid_length) &&
      (last_of_card == ({1'b0, uid_index} + 5'd1 == uid_length)))
    else $error("uid index out of place");

endmodule

bind stx_etx_xor_card_deframer_dedup_core sxd_checker u_sxd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .is_card      (is_card),
  .card_kind    (card_kind),
  .uid_length   (uid_length),
  .uid_index    (uid_index),
  .uid_byte     (uid_byte),
  .last_of_card (last_of_card)
);

FILE: test/tb_stx_etx_xor_card_deframer_dedup_core.sv
// testbench for the stx/etx card deframer core: directed and random event streams,
// each output beat checked field by field against a predictor kept in this file
// depends on sxd_pkg and the core rtl
module tb_stx_etx_xor_card_deframer_dedup_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sxd_pkg::*;

  localparam int UID_BYTES_MAX = 10;
  localparam int BUF_DEPTH     = 18;

  typedef struct packed {
    logic        is_card;
    logic [7:0]  card_kind;
    logic [4:0]  uid_length;
    logic [3:0]  uid_index;
    logic [7:0]  uid_byte;
    logic        last_of_card;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
    logic [31:0] cards_reported;
    logic [31:0] cards_suppressed;
  } card_beat_t;

  typedef logic [7:0] byte_q_t [$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = OP_TICK;
  logic [7:0]  rx_byte = 8'h00;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_card;
  logic [7:0]  card_kind;
  logic [4:0]  uid_length;
  logic [3:0]  uid_index;
  logic [7:0]  uid_byte;
  logic        last_of_card;
  logic [31:0] good_frames;
  logic [31:0] bad_frames;
  logic [31:0] cards_reported;
  logic [31:0] cards_suppressed;

  // predictor state
  logic        in_frame;
  int          frame_len;
  logic [7:0]  frame_buf [BUF_DEPTH];
  logic [7:0]  last_uid [UID_BYTES_MAX];
  int          last_len;
  logic        last_valid;
  logic [15:0] since_ms;
  logic [15:0] window;
  logic [31:0] n_good, n_bad, n_rep, n_sup;

  card_beat_t  beat_q [$];
  byte_q_t     recent_uid;
  int          err_count = 0;
  int          items_sent = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;

  stx_etx_xor_card_deframer_dedup_core #(
    .UID_MAX  (UID_BYTES_MAX),
    .FRAME_CAP(BUF_DEPTH)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .rx_byte         (rx_byte),
    .cfg_wen         (cfg_wen),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .is_card         (is_card),
    .card_kind       (card_kind),
    .uid_length      (uid_length),
    .uid_index       (uid_index),
    .uid_byte        (uid_byte),
    .last_of_card    (last_of_card),
    .good_frames     (good_frames),
    .bad_frames      (bad_frames),
    .cards_reported  (cards_reported),
    .cards_suppressed(cards_suppressed)
  );

  always #6 clk = ~clk;

  // receiver: long hold-off counted here, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    out_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);
  end

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    err_count++;
    if (err_count <= 10)
      $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_beats
    card_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (beat_q.size() == 0) begin
        note_mismatch("beat with nothing pending, uid_byte", 32'h0, 32'(uid_byte));
      end else begin
        want = beat_q.pop_front();
        if (is_card !== want.is_card)
          note_mismatch("is_card", 32'(want.is_card), 32'(is_card));
        if (card_kind !== want.card_kind)
          note_mismatch("card_kind", 32'(want.card_kind), 32'(card_kind));
        if (uid_length !== want.uid_length)
          note_mismatch("uid_length", 32'(want.uid_length), 32'(uid_length));
        if (uid_index !== want.uid_index)
          note_mismatch("uid_index", 32'(want.uid_index), 32'(uid_index));
        if (uid_byte !== want.uid_byte)
          note_mismatch("uid_byte", 32'(want.uid_byte), 32'(uid_byte));
        if (last_of_card !== want.last_of_card)
          note_mismatch("last_of_card", 32'(want.last_of_card), 32'(last_of_card));
        if (good_frames !== want.good_frames)
          note_mismatch("good_frames", want.good_frames, good_frames);
        if (bad_frames !== want.bad_frames)
          note_mismatch("bad_frames", want.bad_frames, bad_frames);
        if (cards_reported !== want.cards_reported)
          note_mismatch("cards_reported", want.cards_reported, cards_reported);
        if (cards_suppressed !== want.cards_suppressed)
          note_mismatch("cards_suppressed", want.cards_suppressed, cards_suppressed);
      end
    end
  end

  // updates the deframer state for one event and queues the beats it gives
  task automatic predict_event(input logic [1:0] op_i, input logic [7:0] b);
    int n, ulen;
    logic [7:0] chk;
    logic same;
    card_beat_t beat;
    ulen = 0;
    case (op_i)
      OP_BYTE: begin
        if (!in_frame) begin
          if (b == START_BYTE) begin
            in_frame = 1'b1;
            frame_len = 0;
          end
        end else if (frame_len >= BUF_DEPTH) begin
          // overflow drops the frame, a start byte opens a new one at once
          n_bad++;
          in_frame = (b == START_BYTE);
          frame_len = 0;
        end else begin
          frame_buf[frame_len] = b;
          frame_len++;
          n = frame_len;
          if (b == END_BYTE && n >= MIN_FRAME && n - FRAME_OVH <= UID_BYTES_MAX) begin
            chk = 8'h00;
            for (int i = 0; i < n - 2; i++) chk ^= frame_buf[i];
            if (chk == frame_buf[n-2]) begin
              n_good++;
              ulen = n - FRAME_OVH;
              same = last_valid && (last_len == ulen);
              for (int i = 0; i < ulen; i++)
                if (same && last_uid[i] != frame_buf[i+2]) same = 1'b0;
              if (same && since_ms < window) begin
                n_sup++;
                ulen = 0;
              end else begin
                for (int i = 0; i < ulen; i++) last_uid[i] = frame_buf[i+2];
                last_len = ulen;
                last_valid = 1'b1;
                n_rep++;
              end
              since_ms = '0;
              in_frame = 1'b0;
              frame_len = 0;
            end
          end
        end
      end
      OP_IDLE: begin
        if (in_frame) begin
          n_bad++;
          in_frame = 1'b0;
          frame_len = 0;
        end
      end
      OP_TICK: begin
        if (since_ms != SINCE_MAX) since_ms++;
      end
      default: begin
        last_valid = 1'b0;
        since_ms = '0;
      end
    endcase
    beat = '0;
    beat.good_frames = n_good;
    beat.bad_frames = n_bad;
    beat.cards_reported = n_rep;
    beat.cards_suppressed = n_sup;
    if (ulen == 0) begin
      beat.last_of_card = 1'b1;
      beat_q.push_back(beat);
    end else begin
      for (int i = 0; i < ulen; i++) begin
        beat.is_card = 1'b1;
        beat.card_kind = frame_buf[1];
        beat.uid_length = 5'(ulen);
        beat.uid_index = 4'(i);
        beat.uid_byte = frame_buf[i+2];
        beat.last_of_card = (i == ulen - 1);
        beat_q.push_back(beat);
      end
    end
  endtask

  // entered with in_valid low or already set to go low
  task automatic send_event(input logic [1:0] op_i, input logic [7:0] b);
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    op <= op_i;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_event(op_i, b);
    in_valid <= 1'b0;
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_event(OP_BYTE, q[i]);
  endtask

  task automatic wait_drained();
    while (beat_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_window(input logic [15:0] ms);
    wait_drained();
    cfg_wen <= 1'b1;
    cfg_wdata <= ms;
    @(posedge clk);
    cfg_wen <= 1'b0;
    window = ms;
  endtask

  // start byte, body, xor of the body, end byte
  function automatic byte_q_t seal_frame(byte_q_t body);
    logic [7:0] chk = 8'h00;
    byte_q_t q;
    foreach (body[i]) chk ^= body[i];
    q = body;
    q.push_front(START_BYTE);
    q.push_back(chk);
    q.push_back(END_BYTE);
    return q;
  endfunction

  function automatic byte_q_t card_frame(logic [7:0] ctype, byte_q_t uid);
    byte_q_t body;
    body = uid;
    body.push_front(ctype);
    body.push_front(8'(uid.size() + 2));
    return seal_frame(body);
  endfunction

  function automatic byte_q_t rand_uid(int len);
    byte_q_t q;
    repeat (len) q.push_back(8'($urandom));
    return q;
  endfunction

  task automatic test_status_events();
    send_event(OP_IDLE, 8'hFF);
    send_event(OP_TICK, 8'h00);
    send_event(OP_CLEAR, 8'hA5);
    // bytes outside a frame are dropped
    send_event(OP_BYTE, 8'h00);
    send_event(OP_BYTE, 8'hFF);
    send_event(OP_BYTE, END_BYTE);
  endtask

  task automatic test_card_frames();
    byte_q_t uid;
    uid = {8'hFF};
    send_bytes(card_frame(8'h00, uid));
    uid = {8'h00, 8'hFF, 8'h81, 8'h7E, 8'h11, 8'h22, 8'h44, 8'h88, 8'hC3, 8'h3C};
    send_bytes(card_frame(8'hFF, uid));
  endtask

  task automatic test_bad_check_continues();
    byte_q_t body;
    // first end byte fails the xor, the frame grows and closes later
    body = {8'h09, 8'h11, 8'hAA, 8'h55, 8'hBD, END_BYTE, 8'h77};
    send_bytes(seal_frame(body));
  endtask

  task automatic test_long_frames();
    byte_q_t q;
    // card data one byte past the limit never closes, idle aborts it
    q.delete();
    for (int i = 0; i < UID_BYTES_MAX + 1; i++) q.push_back(8'(8'h10 + i));
    send_bytes(card_frame(8'h42, q));
    send_event(OP_IDLE, 8'h00);
    // full buffer, then a plain byte
    q.delete();
    q.push_back(START_BYTE);
    for (int i = 0; i < BUF_DEPTH; i++) q.push_back(8'(8'h20 + i));
    send_bytes(q);
    send_event(OP_BYTE, 8'h44);
    // full buffer, then a start byte reopens
    send_bytes(q);
    send_event(OP_BYTE, START_BYTE);
    q = card_frame(8'h07, q[1:3]);
    send_bytes(q[1:$]);
  endtask

  task automatic test_repeat_suppression();
    byte_q_t a, b;
    a = {8'h12, 8'h34};
    b = {8'h12, 8'h34, 8'h56};
    send_bytes(card_frame(8'h01, a));
    send_bytes(card_frame(8'h02, a));   // type is not part of the compare
    repeat (3) send_event(OP_TICK, 8'h00);
    send_bytes(card_frame(8'h01, a));
    send_event(OP_CLEAR, 8'h00);
    send_bytes(card_frame(8'h01, a));
    send_bytes(card_frame(8'h01, b));
    send_bytes(card_frame(8'h01, a));
    set_window(16'd2);
    send_bytes(card_frame(8'h01, a));
    repeat (2) send_event(OP_TICK, 8'h00);
    send_bytes(card_frame(8'h01, a));
    set_window(16'd0);
    send_bytes(card_frame(8'h01, a));
  endtask

  task automatic test_output_hold_off();
    idle_pct = 0;
    stall_pct = 0;
    hold_left <= 400;
    send_bytes(card_frame(8'($urandom), rand_uid(4)));
    repeat (4) send_event(OP_TICK, 8'($urandom));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input logic [15:0] ms);
    int r, k, stop;
    byte_q_t q;
    set_window(ms);
    idle_pct = idle;
    stall_pct = stall;
    stop = items_sent + 10;
    while (items_sent < stop) begin
      r = $urandom_range(99);
      if (r < 50) begin
        if (recent_uid.size() == 0 || $urandom_range(99) < 60)
          recent_uid = rand_uid($urandom_range(UID_BYTES_MAX, 1));
        send_bytes(card_frame(8'($urandom), recent_uid));
      end else if (r < 58) begin
        // broken xor, the frame stays open
        q = card_frame(8'($urandom), rand_uid($urandom_range(UID_BYTES_MAX, 1)));
        q[q.size()-2] ^= 8'(1 << $urandom_range(7));
        send_bytes(q);
      end else if (r < 64) begin
        q = rand_uid($urandom_range(BUF_DEPTH + 2, 12));
        q.push_front(START_BYTE);
        send_bytes(q);
      end else if (r < 70) begin
        q = card_frame(8'($urandom), rand_uid($urandom_range(UID_BYTES_MAX, 1)));
        k = $urandom_range(q.size() - 1, 1);
        for (int i = 0; i < k; i++) send_event(OP_BYTE, q[i]);
        send_event(OP_IDLE, 8'($urandom));
      end else if (r < 84) begin
        repeat ($urandom_range(8, 1)) send_event(OP_TICK, 8'($urandom));
      end else if (r < 88) begin
        send_event(OP_CLEAR, 8'($urandom));
      end else if (r < 93) begin
        send_event(OP_IDLE, 8'($urandom));
      end else begin
        send_event(2'($urandom), 8'($urandom));
      end
      if ($urandom_range(99) < 4) wait_drained();
    end
  endtask

  initial begin
    in_frame = 1'b0;
    frame_len = 0;
    last_len = 0;
    last_valid = 1'b0;
    since_ms = '0;
    window = WINDOW_RESET;
    n_good = '0;
    n_bad = '0;
    n_rep = '0;
    n_sup = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_status_events();
    test_card_frames();
    test_bad_check_continues();
    test_long_frames();
    test_repeat_suppression();
    test_output_hold_off();
    test_random_traffic(0, 0, 16'd6);
    test_random_traffic(85, 0, 16'hFFFF);
    test_random_traffic(0, 85, 16'd0);
    test_random_traffic(24, 24, 16'd3);
    for (int c = 0; c < 200000 && beat_q.size() != 0; c++) @(posedge clk);
    repeat (64) @(posedge clk);
    if (beat_q.size() != 0) note_mismatch("beats still pending", 32'h0, 32'(beat_q.size()));
    if (err_count == 0) begin
      $display("tb_stx_etx_xor_card_deframer_dedup_core: PASS");
    end else begin
      $display("tb_stx_etx_xor_card_deframer_dedup_core: FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb_stx_etx_xor_card_deframer_dedup_core: FAIL");
    $finish;
  end

endmodule
